### sv/asgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgr_pkg
// Shared types, constants and helpers for the SGR colour text cell converter.
// ----------------------------------------------------------------------------
package asgr_pkg;

    // byte codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // register reset values
    localparam logic [3:0] START_FG_RST = 4'h2;
    localparam logic [3:0] START_BG_RST = 4'h0;
    localparam logic [3:0] SGR0_FG_RST  = 4'h7;
    localparam logic [3:0] SGR0_BG_RST  = 4'h0;

    // default sizing
    localparam int CODE_BUFFER_BYTES_DEF = 32;
    localparam int REPLAY_DEPTH_DEF      = 64;
    localparam int CAP_DEPTH             = 64;
    localparam int CAP_AW                = 6;
    localparam int TOKEN_MAX             = 1023;

    // apb map
    localparam int APB_AW = 4;

    typedef enum logic [1:0] {
        REG_START_FG = 2'd0,
        REG_START_BG = 2'd1,
        REG_SGR0_FG  = 2'd2,
        REG_SGR0_BG  = 2'd3
    } reg_idx_t;

    // ansi colour number to cell colour
    localparam logic [3:0] COLOR_MAP [16] = '{
        4'h0, 4'h4, 4'h2, 4'h6, 4'h1, 4'h5, 4'h3, 4'h7,
        4'h8, 4'hC, 4'hA, 4'hE, 4'h9, 4'hD, 4'hB, 4'hF
    };

    typedef struct packed {
        logic [3:0] start_fg;
        logic [3:0] start_bg;
        logic [3:0] sgr0_fg;
        logic [3:0] sgr0_bg;
    } colors_t;

    typedef struct packed {
        logic is_nul;
        logic is_esc;
        logic is_lbr;
        logic is_m;
        logic is_semi;
        logic is_digit;
        logic is_space;
        logic is_sign;
        logic is_minus;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        last;
        byte_class_t cls;
    } item_t;

    typedef struct packed {
        logic [15:0] cell_count;
        logic        buffer_end;
        logic        has_char;
        logic [15:0] cell_word;
    } cell_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_EXEC,
        ST_CRD,
        ST_CWR,
        ST_LBR,
        ST_NEXT
    } back_state_t;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_CAP
    } parse_mode_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        c.is_nul   = (b == CH_NUL);
        c.is_esc   = (b == CH_ESC);
        c.is_lbr   = (b == CH_LBR);
        c.is_m     = (b == CH_M);
        c.is_semi  = (b == CH_SEMI);
        c.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        c.is_space = (b == CH_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
        c.is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
        c.is_minus = (b == CH_MINUS);
        return c;
    endfunction

endpackage
`default_nettype wire

### sv/ansi_sgr_color_text_cells_top.sv
`default_nettype none
// A plain byte gives its cell on the output in the cycle after it is taken; the final
// cell of a buffer waits in the hold register for its end flag, then goes to the output.
// The parser takes no new byte until the last one has passed its execute and dispatch steps.
// A failed escape fills the replay stack (capture read and write per byte, then the
// bracket) and replays it by pop, execute and dispatch. Output stalls hold the parser.
// Reset is asynchronous and active low; it clears control state and restores defaults.
// ----------------------------------------------------------------------------
// ansi_sgr_color_text_cells_top
// Converts text bytes with SGR colour escapes into 16-bit coloured text cells.
// ----------------------------------------------------------------------------
module ansi_sgr_color_text_cells_top #(
    parameter int CODE_BUFFER_BYTES = asgr_pkg::CODE_BUFFER_BYTES_DEF,
    parameter int REPLAY_DEPTH      = asgr_pkg::REPLAY_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] text_byte
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [31:0]                      m_tdata,   // [15:0] cell_word, [31:16] cell_count
    output logic                             m_tlast,
    output logic                             m_tuser,   // [0] has_char
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [asgr_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import asgr_pkg::*;

    colors_t  cfg_reg;
    colors_t  cfg_next;
    reg_idx_t reg_sel;
    logic     wr_en;
    logic     q_valid;
    logic     q_pop;
    item_t    q_item;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_START_FG: cfg_next.start_fg = pwdata[3:0];
                REG_START_BG: cfg_next.start_bg = pwdata[3:0];
                REG_SGR0_FG:  cfg_next.sgr0_fg  = pwdata[3:0];
                REG_SGR0_BG:  cfg_next.sgr0_bg  = pwdata[3:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_START_FG: prdata = {28'd0, cfg_reg.start_fg};
            REG_START_BG: prdata = {28'd0, cfg_reg.start_bg};
            REG_SGR0_FG:  prdata = {28'd0, cfg_reg.sgr0_fg};
            REG_SGR0_BG:  prdata = {28'd0, cfg_reg.sgr0_bg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_fg <= START_FG_RST;
            cfg_reg.start_bg <= START_BG_RST;
            cfg_reg.sgr0_fg  <= SGR0_FG_RST;
            cfg_reg.sgr0_bg  <= SGR0_BG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    asgr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    asgr_back #(
        .CODE_BUFFER_BYTES (CODE_BUFFER_BYTES),
        .REPLAY_DEPTH      (REPLAY_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

### sv/asgr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module asgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### sv/asgr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgr_front
// Input side: classifies each text byte and queues it in a two-word queue.
// ----------------------------------------------------------------------------
module asgr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] text_byte
    input  wire logic          s_tlast,
    output logic               q_valid,
    input  wire logic          q_pop,
    output asgr_pkg::item_t    q_item
);
    import asgr_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage with classified byte
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].text_byte <= s_tdata;
            entry_reg[wr_ptr_reg].last      <= s_tlast;
            entry_reg[wr_ptr_reg].cls       <= classify(s_tdata);
        end
    end

endmodule
`default_nettype wire

### sv/asgr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgr_back
// Parser: escape capture, token decode, replay stack and cell output.
// ----------------------------------------------------------------------------
module asgr_back #(
    parameter int CODE_BUFFER_BYTES = asgr_pkg::CODE_BUFFER_BYTES_DEF,
    parameter int REPLAY_DEPTH      = asgr_pkg::REPLAY_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire asgr_pkg::colors_t cfg,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire asgr_pkg::item_t q_item,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [31:0]          m_tdata,   // [15:0] cell_word, [31:16] cell_count
    output logic                 m_tlast,
    output logic                 m_tuser    // [0] has_char
);
    import asgr_pkg::*;

    localparam int SAW = $clog2(REPLAY_DEPTH);
    localparam int SPW = $clog2(REPLAY_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(REPLAY_DEPTH);
    localparam logic [CAP_AW-1:0] CAP_MAX = CAP_AW'(CODE_BUFFER_BYTES - 1);

    typedef struct packed {
        logic started;
        logic body;
        logic neg;
        logic done;
    } tok_flags_t;

    back_state_t       state_reg, state_next;
    parse_mode_t       mode_reg, mode_next;
    logic [3:0]        cur_fg_reg, cur_fg_next, cur_bg_reg, cur_bg_next;
    logic [3:0]        pend_fg_reg, pend_fg_next, pend_bg_reg, pend_bg_next;
    logic [9:0]        tok_val_reg, tok_val_next;
    tok_flags_t        tok_flags_reg, tok_flags_next;
    logic [CAP_AW-1:0] cap_len_reg, cap_len_next;
    logic [CAP_AW-1:0] idx_reg, idx_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic              stopped_reg, stopped_next;
    logic [15:0]       count_reg, count_next;
    logic              last_reg, last_next;
    cell_out_t         hold_reg, hold_next;
    logic              hold_valid_reg, hold_valid_next;
    cell_out_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // memory ports
    logic              stk_we, stk_re;
    logic [SAW-1:0]    stk_waddr, stk_raddr;
    logic [7:0]        stk_wdata, stk_rdata;
    logic              cap_we, cap_re;
    logic [CAP_AW-1:0] cap_waddr, cap_raddr;
    logic [7:0]        cap_rdata;

    // per cycle requests
    logic              can_adv;
    logic              do_exec;
    logic [7:0]        x;
    byte_class_t       xc;
    logic              push_req;
    logic [7:0]        push_data;
    logic              emit_req;
    logic [7:0]        emit_ch;
    logic              flush_end;
    logic              fail_req;
    logic              fail_has_byte;
    logic [3:0]        fin_fg, fin_bg;
    logic [13:0]       acc;
    logic [9:0]        acc_sat;
    logic [15:0]       cnt_inc;
    cell_out_t         new_cell;

    asgr_ram #(.WIDTH(8), .DEPTH(REPLAY_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    asgr_ram #(.WIDTH(8), .DEPTH(CAP_DEPTH)) u_capture (
        .clk   (clk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (x),
        .re    (cap_re),
        .raddr (cap_raddr),
        .rdata (cap_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.cell_count, out_reg.cell_word};
    assign m_tlast  = out_reg.buffer_end;
    assign m_tuser  = out_reg.has_char;
    assign can_adv  = !out_valid_reg || m_tready;

    // byte under execution comes from the queue or from the replay stack
    always_comb
    begin
        if (state_reg == ST_EXEC)
        begin
            x  = stk_rdata;
            xc = classify(stk_rdata);
        end
        else
        begin
            x  = q_item.text_byte;
            xc = q_item.cls;
        end
    end

    // token close: apply the finished code to the pending colours
    always_comb
    begin
        fin_fg = pend_fg_reg;
        fin_bg = pend_bg_reg;
        if (tok_flags_reg.started && !(tok_flags_reg.neg && (tok_val_reg != 10'd0)))
        begin
            if ((tok_val_reg >= 10'd30) && (tok_val_reg <= 10'd37))
            begin
                fin_fg = COLOR_MAP[{1'b0, 3'(tok_val_reg - 10'd30)}];
            end
            else if ((tok_val_reg >= 10'd90) && (tok_val_reg <= 10'd97))
            begin
                fin_fg = COLOR_MAP[{1'b1, 3'(tok_val_reg - 10'd90)}];
            end
            else if ((tok_val_reg >= 10'd40) && (tok_val_reg <= 10'd47))
            begin
                fin_bg = COLOR_MAP[{1'b0, 3'(tok_val_reg - 10'd40)}];
            end
            else if ((tok_val_reg >= 10'd100) && (tok_val_reg <= 10'd107))
            begin
                fin_bg = COLOR_MAP[{1'b1, 3'(tok_val_reg - 10'd100)}];
            end
            else if (tok_val_reg == 10'd0)
            begin
                fin_fg = cfg.sgr0_fg;
                fin_bg = cfg.sgr0_bg;
            end
        end
    end

    // decimal accumulate with saturation
    always_comb
    begin
        acc     = {4'd0, tok_val_reg} * 14'd10 + {10'd0, 4'(x - CH_ZERO)};
        acc_sat = (acc > 14'(TOKEN_MAX)) ? 10'(TOKEN_MAX) : acc[9:0];
        cnt_inc = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cur_fg_next     = cur_fg_reg;
        cur_bg_next     = cur_bg_reg;
        pend_fg_next    = pend_fg_reg;
        pend_bg_next    = pend_bg_reg;
        tok_val_next    = tok_val_reg;
        tok_flags_next  = tok_flags_reg;
        cap_len_next    = cap_len_reg;
        idx_next        = idx_reg;
        sp_next         = sp_reg;
        stopped_next    = stopped_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        q_pop           = 1'b0;
        stk_re          = 1'b0;
        stk_raddr       = SAW'(sp_reg - SPW'(1));
        cap_we          = 1'b0;
        cap_waddr       = cap_len_reg;
        cap_re          = 1'b0;
        cap_raddr       = idx_reg;
        push_req        = 1'b0;
        push_data       = x;
        emit_req        = 1'b0;
        emit_ch         = x;
        flush_end       = 1'b0;
        fail_req        = 1'b0;
        fail_has_byte   = 1'b0;

        do_exec = can_adv && (((state_reg == ST_IDLE) && q_valid) || (state_reg == ST_EXEC));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_exec)
                begin
                    q_pop      = 1'b1;
                    last_next  = q_item.last;
                    state_next = ST_NEXT;
                end
            end
            ST_EXEC:
            begin
                if (do_exec)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_POP:
            begin
                stk_re     = 1'b1;
                sp_next    = sp_reg - SPW'(1);
                state_next = ST_EXEC;
            end
            ST_CRD:
            begin
                cap_re     = 1'b1;
                state_next = ST_CWR;
            end
            ST_CWR:
            begin
                push_req  = 1'b1;
                push_data = cap_rdata;
                if (idx_reg == '0)
                begin
                    state_next = ST_LBR;
                end
                else
                begin
                    idx_next   = idx_reg - CAP_AW'(1);
                    state_next = ST_CRD;
                end
            end
            ST_LBR:
            begin
                push_req     = 1'b1;
                push_data    = CH_LBR;
                cap_len_next = '0;
                state_next   = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (can_adv)
                begin
                    priority if (sp_reg != '0)
                    begin
                        state_next = ST_POP;
                    end
                    else if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!stopped_reg && (mode_reg == MODE_ESC))
                    begin
                        emit_req  = 1'b1;
                        emit_ch   = CH_ESC;
                        mode_next = MODE_PLAIN;
                    end
                    else if (!stopped_reg && (mode_reg == MODE_CAP))
                    begin
                        fail_req = 1'b1;
                    end
                    else
                    begin
                        // end of buffer: deliver final word and restart
                        flush_end      = 1'b1;
                        cur_fg_next    = cfg.start_fg;
                        cur_bg_next    = cfg.start_bg;
                        pend_fg_next   = 4'h0;
                        pend_bg_next   = 4'h0;
                        mode_next      = MODE_PLAIN;
                        tok_val_next   = '0;
                        tok_flags_next = '0;
                        cap_len_next   = '0;
                        stopped_next   = 1'b0;
                        count_next     = '0;
                        sp_next        = '0;
                        last_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // byte execution
        if (do_exec && !stopped_reg)
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    if (xc.is_lbr)
                    begin
                        mode_next      = MODE_CAP;
                        cap_len_next   = '0;
                        tok_val_next   = '0;
                        tok_flags_next = '0;
                        pend_fg_next   = cur_fg_reg;
                        pend_bg_next   = cur_bg_reg;
                    end
                    else
                    begin
                        emit_req  = 1'b1;
                        emit_ch   = CH_ESC;
                        mode_next = MODE_PLAIN;
                        push_req  = 1'b1;
                    end
                end
                MODE_CAP:
                begin
                    priority if (xc.is_m)
                    begin
                        cur_fg_next    = fin_fg;
                        cur_bg_next    = fin_bg;
                        pend_fg_next   = fin_fg;
                        pend_bg_next   = fin_bg;
                        tok_val_next   = '0;
                        tok_flags_next = '0;
                        mode_next      = MODE_PLAIN;
                        cap_len_next   = '0;
                    end
                    else if (!xc.is_nul && (cap_len_reg < CAP_MAX))
                    begin
                        cap_we       = 1'b1;
                        cap_len_next = cap_len_reg + CAP_AW'(1);
                        if (xc.is_semi)
                        begin
                            pend_fg_next   = fin_fg;
                            pend_bg_next   = fin_bg;
                            tok_val_next   = '0;
                            tok_flags_next = '0;
                        end
                        else
                        begin
                            tok_flags_next.started = 1'b1;
                            if (!tok_flags_reg.done)
                            begin
                                if (!tok_flags_reg.body)
                                begin
                                    priority if (xc.is_space)
                                    begin
                                        tok_flags_next.started = 1'b1;
                                    end
                                    else if (xc.is_sign)
                                    begin
                                        tok_flags_next.body = 1'b1;
                                        tok_flags_next.neg  = xc.is_minus;
                                    end
                                    else if (!xc.is_digit)
                                    begin
                                        tok_flags_next.done = 1'b1;
                                    end
                                    else
                                    begin
                                        tok_flags_next.body = 1'b1;
                                        tok_val_next        = acc_sat;
                                    end
                                end
                                else if (xc.is_digit)
                                begin
                                    tok_val_next = acc_sat;
                                end
                                else
                                begin
                                    tok_flags_next.done = 1'b1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        fail_req      = 1'b1;
                        fail_has_byte = 1'b1;
                    end
                end
                default:
                begin
                    priority if (xc.is_nul)
                    begin
                        stopped_next = 1'b1;
                        sp_next      = '0;
                    end
                    else if (xc.is_esc)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        emit_req = 1'b1;
                    end
                end
            endcase
        end

        // failed escape: emit esc, then replay the capture
        if (fail_req)
        begin
            emit_req   = 1'b1;
            emit_ch    = CH_ESC;
            mode_next  = MODE_PLAIN;
            push_req   = fail_has_byte;
            idx_next   = cap_len_reg - CAP_AW'(1);
            state_next = (cap_len_reg != '0) ? ST_CRD : ST_LBR;
        end

        // replay stack push, dropped when full
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = push_data;
        if (push_req && (sp_reg < SP_FULL))
        begin
            stk_we  = 1'b1;
            sp_next = sp_reg + SPW'(1);
        end

        // cell emission, last cell of a buffer held back for its end flag
        new_cell.cell_word  = {cur_bg_reg, cur_fg_reg, emit_ch};
        new_cell.has_char   = 1'b1;
        new_cell.buffer_end = 1'b0;
        new_cell.cell_count = cnt_inc;
        if (emit_req)
        begin
            count_next = cnt_inc;
            if (last_next)
            begin
                if (hold_valid_reg)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                end
                hold_next       = new_cell;
                hold_valid_next = 1'b1;
            end
            else
            begin
                out_next       = new_cell;
                out_valid_next = 1'b1;
            end
        end

        // final word of a buffer
        if (flush_end)
        begin
            out_valid_next = 1'b1;
            if (hold_valid_reg)
            begin
                out_next            = hold_reg;
                out_next.buffer_end = 1'b1;
                hold_valid_next     = 1'b0;
            end
            else
            begin
                out_next.cell_word  = '0;
                out_next.has_char   = 1'b0;
                out_next.buffer_end = 1'b1;
                out_next.cell_count = count_reg;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_PLAIN;
            cur_fg_reg     <= START_FG_RST;
            cur_bg_reg     <= START_BG_RST;
            pend_fg_reg    <= 4'h0;
            pend_bg_reg    <= 4'h0;
            tok_val_reg    <= '0;
            tok_flags_reg  <= '0;
            cap_len_reg    <= '0;
            idx_reg        <= '0;
            sp_reg         <= '0;
            stopped_reg    <= 1'b0;
            count_reg      <= '0;
            last_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            cur_fg_reg     <= cur_fg_next;
            cur_bg_reg     <= cur_bg_next;
            pend_fg_reg    <= pend_fg_next;
            pend_bg_reg    <= pend_bg_next;
            tok_val_reg    <= tok_val_next;
            tok_flags_reg  <= tok_flags_next;
            cap_len_reg    <= cap_len_next;
            idx_reg        <= idx_next;
            sp_reg         <= sp_next;
            stopped_reg    <= stopped_next;
            count_reg      <= count_next;
            last_reg       <= last_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

endmodule
`default_nettype wire
